// File: rtl/slcd_pkg.sv
// Package for the sync/length/checksum deframer.
// Holds status codes, register indexes and frame constants; no dependencies.
`timescale 1ns / 1ps
package slcd_pkg;
  localparam logic [1:0] ST_DATA    = 2'd0;
  localparam logic [1:0] ST_CSUM    = 2'd1;
  localparam logic [1:0] ST_TOOLONG = 2'd2;
  localparam logic CFG_SYNC_FIRST  = 1'b0;
  localparam logic CFG_SYNC_SECOND = 1'b1;
  localparam int OVERHEAD_BYTES = 7;
  localparam int SKIP_BYTES     = 3;
endpackage

// File: rtl/slcd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module slcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/sync_length_checksum_deframer.sv
// Top level of the sync/length/checksum deframer.
// Depends on slcd_pkg and slcd_ram.
//
// channel | role           | beat contents
// in_     | byte stream in | tdata rx_byte
// out_    | result stream  | tdata cmd_type..data_byte, tuser status/data_valid, tlast last
// cfg_    | register write | index 0 sync_first, 1 sync_second
//
// Each accepted byte is stored if the buffer has room, then the buffer is rescanned from
// offset 0 over the single registered RAM read port, a read state before each byte used:
// a space test, the header bytes up to a sync miss or the length, the length check, the
// checksum walk over len+7 bytes, a launch per payload, error or empty beat, then a move
// of remaining bytes to the buffer start. Reset goes to idle, clears fill count and output
// valid and sets sync registers to 8'h55 and 8'hAA. A stalled beat holds in the output
// register and the next beat waits for it; no byte is taken until the rescan finishes.
`timescale 1ns / 1ps
module sync_length_checksum_deframer #(
  parameter int BUFFER_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] cmd_type, [15:8] version, [21:16] payload_len, [27:22] byte_index,
  // [35:28] data_byte, [39:36] zero
  output logic [39:0] out_tdata,
  output logic [7:0]  out_tuser,    // [1:0] status, [2] data_valid, [7:3] zero
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import slcd_pkg::*;

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int CW = $clog2(BUFFER_BYTES + 1);
  localparam int LW = 6;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_HRD, S_HDR, S_LEN, S_SRD, S_SUM, S_DRD, S_OUT, S_MV, S_MVW
  } state_t;

  state_t         state_r;
  logic [CW-1:0]  fill_r, off_r, cnt_r;
  logic [7:0]     sf_r, ss_r, ver_r, typ_r, lhi_r, llo_r, sum_r;
  logic [1:0]     pst_r;
  logic [LW-1:0]  plf_r;
  logic           pdat_r;
  logic [39:0]    od_r;
  logic [2:0]     ou_r;
  logic           ol_r, ov_r;
  logic [AW-1:0]  raddr, waddr;
  logic [7:0]     rdata, wdata;
  logic           we, launch, last_byte;
  logic [CW-1:0]  avail, total;
  logic [16:0]    tot17;

  assign avail     = fill_r - off_r;
  assign tot17     = {1'b0, lhi_r, llo_r} + 17'(OVERHEAD_BYTES);
  assign total     = CW'(tot17);
  assign last_byte = (cnt_r == total - CW'(2));
  assign launch    = (state_r == S_OUT) && (!ov_r || out_tready);

  slcd_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // RAM port steering
  always_comb begin
    we    = 1'b0;
    waddr = AW'(fill_r);
    wdata = in_tdata;
    raddr = AW'(off_r + cnt_r);
    if (state_r == S_IDLE) begin
      we = in_tvalid && (fill_r < CW'(BUFFER_BYTES));
    end else if (state_r == S_MVW) begin
      we    = 1'b1;
      waddr = AW'(cnt_r);
      wdata = rdata;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = {5'd0, ou_r};
  assign out_tlast  = ol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      ov_r    <= 1'b0;
      sf_r    <= 8'h55;
      ss_r    <= 8'hAA;
    end else begin
      // register writes
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SYNC_FIRST:  sf_r <= cfg_wdata;
          CFG_SYNC_SECOND: ss_r <= cfg_wdata;
          default: ;
        endcase
      end
      // hold the beat until taken
      ov_r <= launch || (ov_r && !out_tready);
      unique case (state_r)
        // store the byte if there is room, restart the scan
        S_IDLE: begin
          if (in_tvalid) begin
            if (fill_r < CW'(BUFFER_BYTES)) fill_r <= fill_r + CW'(1);
            off_r   <= '0;
            state_r <= S_CHK;
          end
        end
        // test space for a header
        S_CHK: begin
          cnt_r <= '0;
          if (avail >= CW'(OVERHEAD_BYTES)) state_r <= S_HRD;
          else state_r <= S_MV;
        end
        S_HRD: state_r <= S_HDR;
        // collect header bytes; drop one byte on a sync miss
        S_HDR: begin
          if ((cnt_r == CW'(0) && rdata != sf_r) || (cnt_r == CW'(1) && rdata != ss_r)) begin
            off_r   <= off_r + CW'(1);
            state_r <= S_CHK;
          end else if (cnt_r == CW'(5)) begin
            llo_r   <= rdata;
            state_r <= S_LEN;
          end else begin
            cnt_r   <= cnt_r + CW'(1);
            state_r <= S_HRD;
          end
          if (cnt_r == CW'(2)) ver_r <= rdata;
          if (cnt_r == CW'(3)) typ_r <= rdata;
          if (cnt_r == CW'(4)) lhi_r <= rdata;
        end
        // length checks: flag too long, wait for more bytes, or start the checksum walk
        S_LEN: begin
          if (tot17 > 17'(BUFFER_BYTES)) begin
            pst_r   <= ST_TOOLONG;
            plf_r   <= '0;
            pdat_r  <= 1'b0;
            off_r   <= off_r + CW'(SKIP_BYTES);
            state_r <= S_OUT;
          end else if (avail < total) begin
            cnt_r   <= '0;
            state_r <= S_MV;
          end else begin
            sum_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_SRD;
          end
        end
        S_SRD: state_r <= S_SUM;
        // accumulate; last byte is the checksum
        S_SUM: begin
          if (cnt_r == total - CW'(1)) begin
            if (rdata != sum_r) begin
              pst_r   <= ST_CSUM;
              plf_r   <= llo_r[LW-1:0];
              pdat_r  <= 1'b0;
              off_r   <= off_r + CW'(SKIP_BYTES);
              state_r <= S_OUT;
            end else if ({lhi_r, llo_r} == 16'd0) begin
              pst_r   <= ST_DATA;
              plf_r   <= '0;
              pdat_r  <= 1'b0;
              off_r   <= off_r + total;
              state_r <= S_OUT;
            end else begin
              pst_r   <= ST_DATA;
              plf_r   <= llo_r[LW-1:0];
              pdat_r  <= 1'b1;
              cnt_r   <= CW'(6);
              state_r <= S_DRD;
            end
          end else begin
            sum_r   <= sum_r + rdata;
            cnt_r   <= cnt_r + CW'(1);
            state_r <= S_SRD;
          end
        end
        S_DRD: state_r <= S_OUT;
        // launch one beat once the output register is free
        S_OUT: begin
          if (launch) begin
            if (pdat_r) begin
              od_r <= {4'd0, rdata, LW'(cnt_r - CW'(6)), plf_r, ver_r, typ_r};
              ou_r <= {1'b1, ST_DATA};
              ol_r <= last_byte;
              if (last_byte) begin
                off_r   <= off_r + total;
                state_r <= S_CHK;
              end else begin
                cnt_r   <= cnt_r + CW'(1);
                state_r <= S_DRD;
              end
            end else begin
              od_r    <= {4'd0, 8'd0, 6'd0, plf_r, ver_r, typ_r};
              ou_r    <= {1'b0, pst_r};
              ol_r    <= 1'b1;
              state_r <= S_CHK;
            end
          end
        end
        // compact remaining bytes to the buffer start
        S_MV: begin
          if (off_r == '0 || cnt_r == avail) begin
            fill_r  <= avail;
            state_r <= S_IDLE;
          end else state_r <= S_MVW;
        end
        S_MVW: begin
          cnt_r   <= cnt_r + CW'(1);
          state_r <= S_MV;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // assertions
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(BUFFER_BYTES)) else $error("fill over buffer");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast)) else $error("result dropped");
  a_off: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> off_r <= fill_r) else $error("offset past fill");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[1:0] <= ST_TOOLONG) else $error("bad status");
  a_dvalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[1:0] == ST_DATA)
    else $error("data on error beat");
endmodule
